// ----- design/versatile_interface_timers_irq_unit_assert.svh -----
// ----------------------------------------------------------------------------
// versatile_interface_timers_irq_unit_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef VERSATILE_INTERFACE_TIMERS_IRQ_UNIT_ASSERT_SVH
`define VERSATILE_INTERFACE_TIMERS_IRQ_UNIT_ASSERT_SVH

// property checked only while reset is low
`define VITI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("viti assertion failed");

// property checked on every edge, reset included
`define VITI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("viti assertion failed");

`endif

// ----- design/viti_pkg.sv -----
// ----------------------------------------------------------------------------
// viti_pkg
// shared types, codes and constants of the interface adapter
// ----------------------------------------------------------------------------
package viti_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } viti_req_e;

  typedef enum logic [3:0] {
    REG_ORB    = 4'd0,
    REG_ORA    = 4'd1,
    REG_DDRB   = 4'd2,
    REG_DDRA   = 4'd3,
    REG_T1CL   = 4'd4,
    REG_T1CH   = 4'd5,
    REG_T1LL   = 4'd6,
    REG_T1LH   = 4'd7,
    REG_T2CL   = 4'd8,
    REG_T2CH   = 4'd9,
    REG_SR     = 4'd10,
    REG_ACR    = 4'd11,
    REG_PCR    = 4'd12,
    REG_IFR    = 4'd13,
    REG_IER    = 4'd14,
    REG_ORA_NH = 4'd15
  } viti_reg_e;

  localparam int FLAG_T1     = 6;
  localparam int FLAG_T2     = 5;
  localparam int FLAG_ANY    = 7;
  localparam int ACR_T1_FREE = 6;
  localparam int ACR_T2_HALT = 5;
  localparam int IER_SET     = 7;

  localparam logic [15:0] TICK_STEP_RESET = 16'd100;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } viti_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } viti_out_t;

endpackage

// ----- design/viti_core.sv -----
// ----------------------------------------------------------------------------
// viti_core
// register file, timers and interrupt logic; one item per enabled cycle
// ----------------------------------------------------------------------------
module viti_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               step_en,
  input  viti_pkg::viti_in_t item,
  output viti_pkg::viti_out_t result
);
  import viti_pkg::*;

  logic [15:0] tick_step;
  logic [7:0]  port_b_out, port_a_out, dir_b, dir_a;
  logic [15:0] t1_count, t1_reload, t2_count;
  logic [7:0]  t2_low_latch, shift_byte, aux_control, periph_control;
  logic [7:0]  int_flags;
  logic [6:0]  int_enables;

  logic [7:0]  port_b_out_next, port_a_out_next, dir_b_next, dir_a_next;
  logic [15:0] t1_count_next, t1_reload_next, t2_count_next;
  logic [7:0]  t2_low_latch_next, shift_byte_next, aux_control_next;
  logic [7:0]  periph_control_next;
  logic [7:0]  int_flags_next;
  logic [6:0]  int_enables_next;

  logic [7:0]  flags_work;
  logic        irq_update;
  logic        t2_expired;
  logic [7:0]  rd;
  logic [7:0]  wd;

  assign wd = item.write_data;

  always_comb begin
    port_b_out_next     = port_b_out;
    port_a_out_next     = port_a_out;
    dir_b_next          = dir_b;
    dir_a_next          = dir_a;
    t1_count_next       = t1_count;
    t1_reload_next      = t1_reload;
    t2_count_next       = t2_count;
    t2_low_latch_next   = t2_low_latch;
    shift_byte_next     = shift_byte;
    aux_control_next    = aux_control;
    periph_control_next = periph_control;
    int_enables_next    = int_enables;
    flags_work          = int_flags;
    irq_update          = 1'b0;
    t2_expired          = 1'b0;
    rd                  = 8'd0;

    case (item.req_type)
      REQ_READ: begin
        case (item.reg_addr)
          REG_ORB:    rd = (item.port_b_pins & ~dir_b) | (port_b_out & dir_b);
          REG_ORA:    rd = (item.port_a_pins & ~dir_a) | (port_a_out & dir_a);
          REG_DDRB:   rd = dir_b;
          REG_DDRA:   rd = dir_a;
          REG_T1CL: begin
            rd                  = t1_count[7:0];
            flags_work[FLAG_T1] = 1'b0;
            irq_update          = 1'b1;
          end
          REG_T1CH:   rd = t1_count[15:8];
          REG_T1LL:   rd = t1_reload[7:0];
          REG_T1LH:   rd = t1_reload[15:8];
          REG_T2CL: begin
            rd                  = t2_count[7:0];
            flags_work[FLAG_T2] = 1'b0;
            irq_update          = 1'b1;
          end
          REG_T2CH:   rd = t2_count[15:8];
          REG_SR:     rd = shift_byte;
          REG_ACR:    rd = aux_control;
          REG_PCR:    rd = periph_control;
          REG_IFR:    rd = int_flags;
          REG_IER:    rd = {1'b0, int_enables};
          REG_ORA_NH: rd = item.port_a_pins;
          default:    rd = 8'd0;
        endcase
      end
      REQ_WRITE: begin
        case (item.reg_addr)
          REG_ORB:  port_b_out_next = wd;
          REG_ORA:  port_a_out_next = wd;
          REG_DDRB: begin
            dir_b_next = wd;
            irq_update = 1'b1;
          end
          REG_DDRA: begin
            dir_a_next = wd;
            irq_update = 1'b1;
          end
          REG_T1CL, REG_T1LL: t1_reload_next = {t1_reload[15:8], wd};
          REG_T1CH: begin
            // load high latch, start timer 1 from the full latch
            t1_reload_next      = {wd, t1_reload[7:0]};
            t1_count_next       = {wd, t1_reload[7:0]};
            flags_work[FLAG_T1] = 1'b0;
            irq_update          = 1'b1;
          end
          REG_T1LH: t1_reload_next = {wd, t1_reload[7:0]};
          REG_T2CL: t2_low_latch_next = wd;
          REG_T2CH: begin
            t2_count_next       = {wd, t2_low_latch};
            flags_work[FLAG_T2] = 1'b0;
            irq_update          = 1'b1;
          end
          REG_SR:   shift_byte_next = wd;
          REG_ACR:  aux_control_next = wd;
          REG_PCR:  periph_control_next = wd;
          REG_IFR: begin
            flags_work = int_flags & ~wd;
            irq_update = 1'b1;
          end
          REG_IER: begin
            if (wd[IER_SET]) begin
              int_enables_next = int_enables | wd[6:0];
            end else begin
              int_enables_next = int_enables & ~wd[6:0];
            end
            irq_update = 1'b1;
          end
          REG_ORA_NH: port_a_out_next = wd;
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (t1_count != 16'd0) begin
          if (tick_step >= t1_count) begin
            flags_work[FLAG_T1] = 1'b1;
            irq_update          = 1'b1;
            t1_count_next       = aux_control[ACR_T1_FREE] ? t1_reload + 16'd1 : 16'd0;
          end else begin
            t1_count_next = t1_count - tick_step;
          end
        end
        if (t2_count != 16'd0 && !aux_control[ACR_T2_HALT]) begin
          t2_expired = tick_step >= t2_count;
          if (t2_expired) begin
            flags_work[FLAG_T2] = 1'b1;
            irq_update          = 1'b1;
          end
          // after expiry the count wraps down from zero
          t2_count_next = (t2_expired ? 16'd0 : t2_count) - tick_step;
        end
      end
      default: ;
    endcase

    int_flags_next = flags_work;
    if (irq_update) begin
      int_flags_next[FLAG_ANY] = |(int_enables_next & flags_work[6:0]);
    end

    result.read_data = rd;
    result.irq       = |(int_enables_next & int_flags_next[6:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
    end else if (cfg_we) begin
      tick_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_b_out     <= '0;
      port_a_out     <= '0;
      dir_b          <= '0;
      dir_a          <= '0;
      t1_count       <= '0;
      t1_reload      <= '0;
      t2_count       <= '0;
      t2_low_latch   <= '0;
      shift_byte     <= '0;
      aux_control    <= '0;
      periph_control <= '0;
      int_flags      <= '0;
      int_enables    <= '0;
    end else if (step_en) begin
      port_b_out     <= port_b_out_next;
      port_a_out     <= port_a_out_next;
      dir_b          <= dir_b_next;
      dir_a          <= dir_a_next;
      t1_count       <= t1_count_next;
      t1_reload      <= t1_reload_next;
      t2_count       <= t2_count_next;
      t2_low_latch   <= t2_low_latch_next;
      shift_byte     <= shift_byte_next;
      aux_control    <= aux_control_next;
      periph_control <= periph_control_next;
      int_flags      <= int_flags_next;
      int_enables    <= int_enables_next;
    end
  end

endmodule

// ----- design/versatile_interface_timers_irq_unit.sv -----
// ----------------------------------------------------------------------------
// versatile_interface_timers_irq_unit: two-timer interface adapter with irq
// result path: the input register holds the item, its result is captured in
// the output register and transferred out when the output is free
// throughput: 1 item per cycle unless the output stalls, single-pass core step
// reset: synchronous, clears valid flags and core state, tick_step back to 100
// ----------------------------------------------------------------------------
module versatile_interface_timers_irq_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  viti_pkg::viti_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output viti_pkg::viti_out_t out_item
);
  import viti_pkg::*;

  // input register: holds the accepted item until the core consumes it
  logic      s1_valid;
  viti_in_t  s1_item;

  // core result for the item in the input register
  viti_out_t core_result;

  // the item advances when the output register is empty or being drained
  logic      advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  // a new transfer is taken whenever the input register empties this cycle
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // state registers update on the same edge the result is captured
  viti_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (advance),
    .item      (s1_item),
    .result    (core_result)
  );

  // output register: keeps a finished result while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

endmodule

// ----- design/viti_checker.sv -----
// ----------------------------------------------------------------------------
// viti_checker
// port-level checks of the interface adapter, bound to the top level
// ----------------------------------------------------------------------------
`include "versatile_interface_timers_irq_unit_assert.svh"

module viti_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input viti_pkg::viti_out_t out_item
);
  import viti_pkg::*;

  // a stalled result keeps its value
  `VITI_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item))

  // input only backs up when the output side is stalled
  `VITI_ASSERT(a_in_backpressure, clk, rst, !in_ready |-> out_valid && !out_ready)

  // reset leaves no result and an open input
  `VITI_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && in_ready)

endmodule

bind versatile_interface_timers_irq_unit viti_checker u_viti_checker (.*);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of versatile_interface_timers_irq_unit
// drives register reads, register writes and timer ticks through the input
// channel, runs a cycle-free model of the adapter on every accepted transfer
// and compares each returned read byte and irq level in order, under several
// tick_step settings and several patterns of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb;
  import viti_pkg::*;

  // request code with no function, must leave every register alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // cycles with no transfer on either side before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // length of the forced receiver hold-off that fills the block
  localparam int HOLD_CYCLES = 300;
  // random items per phase
  localparam int PHASE_ITEMS = 170;
  localparam int NUM_PHASES  = 6;

  typedef enum {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_e;

  // one line of the directed table
  typedef struct {
    viti_in_t  item;
    bit        known;
    viti_out_t want;
  } row_t;

  logic      clk;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  viti_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  viti_out_t out_item;

  versatile_interface_timers_irq_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // clock, period 10
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // adapter model: register file, timers and flags
  // --------------------------------------------------------------------------
  logic [7:0]  pb_out, pa_out, ddr_b, ddr_a;
  logic [15:0] t1_cnt, t1_latch, t2_cnt;
  logic [7:0]  t2_lat_lo, sr_byte, acr, pcr, ifr;
  logic [6:0]  ier;
  logic [15:0] step_size;

  viti_out_t   read_q[$];   // expected read bytes and irq levels, oldest first
  int          errs = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          rx_hold_left = 0;

  function automatic void clear_adapter();
    pb_out = '0; pa_out = '0; ddr_b = '0; ddr_a = '0;
    t1_cnt = '0; t1_latch = '0; t2_cnt = '0; t2_lat_lo = '0;
    sr_byte = '0; acr = '0; pcr = '0; ifr = '0; ier = '0;
    step_size = TICK_STEP_RESET;
  endfunction

  // flag register bit 7 mirrors any enabled flag
  function automatic void refresh_any();
    ifr[FLAG_ANY] = |(ier & ifr[6:0]);
  endfunction

  function automatic viti_out_t via_step(viti_in_t it);
    logic [7:0] rd;
    logic [7:0] v;
    viti_out_t  r;
    rd = '0;
    v  = it.write_data;
    if (it.req_type == REQ_READ) begin
      case (viti_reg_e'(it.reg_addr))
        REG_ORB:  rd = (it.port_b_pins & ~ddr_b) | (pb_out & ddr_b);
        REG_ORA:  rd = (it.port_a_pins & ~ddr_a) | (pa_out & ddr_a);
        REG_DDRB: rd = ddr_b;
        REG_DDRA: rd = ddr_a;
        REG_T1CL: begin
          // low counter read acknowledges timer 1
          ifr[FLAG_T1] = 1'b0;
          refresh_any();
          rd = t1_cnt[7:0];
        end
        REG_T1CH: rd = t1_cnt[15:8];
        REG_T1LL: rd = t1_latch[7:0];
        REG_T1LH: rd = t1_latch[15:8];
        REG_T2CL: begin
          ifr[FLAG_T2] = 1'b0;
          refresh_any();
          rd = t2_cnt[7:0];
        end
        REG_T2CH: rd = t2_cnt[15:8];
        REG_SR:   rd = sr_byte;
        REG_ACR:  rd = acr;
        REG_PCR:  rd = pcr;
        REG_IFR:  rd = ifr;
        REG_IER:  rd = {1'b0, ier};
        default:  rd = it.port_a_pins;
      endcase
    end else if (it.req_type == REQ_WRITE) begin
      case (viti_reg_e'(it.reg_addr))
        REG_ORB: pb_out = v;
        REG_DDRB: begin
          ddr_b = v;
          refresh_any();
        end
        REG_DDRA: begin
          ddr_a = v;
          refresh_any();
        end
        REG_T1CL, REG_T1LL: t1_latch[7:0] = v;
        REG_T1CH: begin
          // high byte write loads the counter and acknowledges timer 1
          t1_latch[15:8] = v;
          t1_cnt = t1_latch;
          ifr[FLAG_T1] = 1'b0;
          refresh_any();
        end
        REG_T1LH: t1_latch[15:8] = v;
        REG_T2CL: t2_lat_lo = v;
        REG_T2CH: begin
          t2_cnt = {v, t2_lat_lo};
          ifr[FLAG_T2] = 1'b0;
          refresh_any();
        end
        REG_SR:  sr_byte = v;
        REG_ACR: acr = v;
        REG_PCR: pcr = v;
        REG_IFR: begin
          ifr = ifr & ~v;
          refresh_any();
        end
        REG_IER: begin
          if (v[IER_SET]) begin
            ier = ier | v[6:0];
          end else begin
            ier = ier & ~v[6:0];
          end
          refresh_any();
        end
        default: pa_out = v;
      endcase
    end else if (it.req_type == REQ_TICK) begin
      // timer 1 stops at zero unless free-running
      if (t1_cnt != 16'd0) begin
        if (step_size >= t1_cnt) begin
          ifr[FLAG_T1] = 1'b1;
          refresh_any();
          t1_cnt = acr[ACR_T1_FREE] ? t1_latch + 16'd1 : 16'd0;
        end else begin
          t1_cnt = t1_cnt - step_size;
        end
      end
      // timer 2 restarts from zero on expiry and keeps wrapping down
      if (t2_cnt != 16'd0 && !acr[ACR_T2_HALT]) begin
        if (step_size >= t2_cnt) begin
          ifr[FLAG_T2] = 1'b1;
          refresh_any();
          t2_cnt = 16'd0;
        end
        t2_cnt = t2_cnt - step_size;
      end
    end
    r.read_data = rd;
    r.irq       = |(ier & ifr[6:0]);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic row_t row(logic [1:0] k, viti_reg_e a, logic [7:0] d,
                               logic [7:0] pa, logic [7:0] pb, bit known,
                               logic [7:0] rd, logic irq);
    row_t r;
    r.item.req_type    = k;
    r.item.reg_addr    = a;
    r.item.write_data  = d;
    r.item.port_a_pins = pa;
    r.item.port_b_pins = pb;
    r.known            = known;
    r.want.read_data   = rd;
    r.want.irq         = irq;
    return r;
  endfunction

  function automatic viti_in_t rand_item();
    viti_in_t it;
    int       pick;
    it.port_a_pins = 8'($urandom);
    it.port_b_pins = 8'($urandom);
    it.reg_addr    = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.req_type = REQ_READ;
    end else if (pick < 65) begin
      it.req_type = REQ_WRITE;
    end else if (pick < 96) begin
      it.req_type = REQ_TICK;
    end else begin
      it.req_type = REQ_UNUSED;
    end
    case ($urandom_range(0, 7))
      0:       it.write_data = 8'h00;
      1:       it.write_data = 8'hFF;
      default: it.write_data = 8'($urandom);
    endcase
    return it;
  endfunction

  // offer one item, hold it until the transfer, then record what should return
  task automatic send(viti_in_t it, bit known, viti_out_t want);
    viti_out_t guess;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    // model always advances, typed rows override its answer
    guess = via_step(it);
    read_q.push_back(known ? want : guess);
  endtask

  // stop offering and wait for every outstanding result plus pipe latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (read_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    step_size = v;
  endtask

  function automatic void set_pace(pace_e p);
    case (p)
      PACE_SEND_GAPS: begin
        send_idle_pct = 87;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALLS: begin
        send_idle_pct = 0;
        recv_stall_pct = 87;
      end
      PACE_BOTH: begin
        send_idle_pct = 25;
        recv_stall_pct = 25;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // result side: compare every transfer out against the oldest expectation
  // --------------------------------------------------------------------------
  initial begin
    viti_out_t w;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (read_q.size() == 0) begin
          $display("%0t: unexpected result read_data=%h irq=%b", $time,
                   out_item.read_data, out_item.irq);
          errs++;
        end else begin
          w = read_q.pop_front();
          if (out_item.read_data !== w.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time,
                     w.read_data, out_item.read_data);
            errs++;
          end
          if (out_item.irq !== w.irq) begin
            $display("%0t: irq expected %b actual %b", $time, w.irq, out_item.irq);
            errs++;
          end
        end
      end
      // long hold-off counted here, otherwise random stalls
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t        dir_tab[$];
    viti_in_t    it;
    viti_out_t   none;
    logic [15:0] step_v;
    bit          on_t2;
    int          n;

    none = '0;
    clear_adapter();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk, tick_step still at its reset value
    dir_tab = '{
      // all registers clear after reset
      row(REQ_READ,   REG_IFR,    8'h00, 8'h00, 8'h00, 1, 8'h00, 1'b0),
      // inputs everywhere: pins come straight through
      row(REQ_READ,   REG_ORB,    8'h00, 8'h00, 8'hA5, 1, 8'hA5, 1'b0),
      row(REQ_READ,   REG_ORA_NH, 8'h00, 8'hFF, 8'h00, 1, 8'hFF, 1'b0),
      // unused request code with every field at ones
      row(REQ_UNUSED, REG_ORA_NH, 8'hFF, 8'hFF, 8'hFF, 1, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_DDRB,   8'hFF, 8'h00, 8'h00, 1, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_ORB,    8'h5A, 8'h00, 8'h00, 1, 8'h00, 1'b0),
      // outputs everywhere: pins masked off
      row(REQ_READ,   REG_ORB,    8'h00, 8'h00, 8'hFF, 1, 8'h5A, 1'b0),
      row(REQ_WRITE,  REG_IER,    8'hFF, 8'h00, 8'h00, 1, 8'h00, 1'b0),
      row(REQ_READ,   REG_IER,    8'h00, 8'h00, 8'h00, 1, 8'h7F, 1'b0),
      // timer 1 one-shot from 2, expires on the first tick
      row(REQ_WRITE,  REG_T1CL,   8'h02, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_T1CH,   8'h00, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_TICK,   REG_ORB,    8'h00, 8'h00, 8'h00, 1, 8'h00, 1'b1),
      row(REQ_READ,   REG_IFR,    8'h00, 8'h00, 8'h00, 1, 8'hC0, 1'b1),
      row(REQ_READ,   REG_T1CL,   8'h00, 8'h00, 8'h00, 1, 8'h00, 1'b0),
      // timer 1 parked at zero does not fire again
      row(REQ_TICK,   REG_IER,    8'hFF, 8'hFF, 8'hFF, 1, 8'h00, 1'b0),
      // free-run with a latch of all ones: reload wraps to zero and stops
      row(REQ_WRITE,  REG_ACR,    8'h40, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_T1LL,   8'h32, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_T1CH,   8'h00, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_T1LH,   8'hFF, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_T1LL,   8'hFF, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_TICK,   REG_ORB,    8'h00, 8'h00, 8'h00, 1, 8'h00, 1'b1),
      row(REQ_READ,   REG_T1CH,   8'h00, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      // timer 2 expiry then wrap from the top
      row(REQ_WRITE,  REG_T2CL,   8'h0A, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_T2CH,   8'h00, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_TICK,   REG_ORB,    8'h00, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      row(REQ_READ,   REG_T2CL,   8'h00, 8'h00, 8'h00, 0, 8'h00, 1'b0),
      // acknowledge everything, disable everything
      row(REQ_WRITE,  REG_IFR,    8'h7F, 8'h00, 8'h00, 1, 8'h00, 1'b0),
      row(REQ_WRITE,  REG_IER,    8'h7F, 8'h00, 8'h00, 1, 8'h00, 1'b0)
    };
    set_pace(PACE_FULL);
    foreach (dir_tab[i]) send(dir_tab[i].item, dir_tab[i].known, dir_tab[i].want);

    // random phases, each under its own tick_step and pacing
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0:       step_v = TICK_STEP_RESET;
        1:       step_v = 16'd1;
        2:       step_v = 16'hFFFF;
        3:       step_v = 16'($urandom_range(2, 65534));
        4:       step_v = 16'd0;
        default: step_v = 16'd7;
      endcase
      write_step(step_v);
      case (ph)
        1:       set_pace(PACE_SEND_GAPS);
        2:       set_pace(PACE_RECV_STALLS);
        3:       set_pace(PACE_BOTH);
        5:       set_pace(PACE_BOTH);
        default: set_pace(PACE_FULL);
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        // halfway through the first phase the sender waits for all results
        if (ph == 0 && n == PHASE_ITEMS / 2) begin
          drain();
        end
        // in phase 4, run at full rate, the receiver blocks for a long stretch
        if (ph == 4 && n == PHASE_ITEMS / 3) begin
          rx_hold_left = HOLD_CYCLES;
        end
        if ($urandom_range(0, 4) == 0) begin
          // timer load: low latch then high byte, mostly short counts
          on_t2 = 1'($urandom_range(0, 1));
          it = rand_item();
          it.req_type   = REQ_WRITE;
          it.reg_addr   = on_t2 ? REG_T2CL : REG_T1LL;
          it.write_data = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                               : 8'($urandom);
          send(it, 0, none);
          it = rand_item();
          it.req_type   = REQ_WRITE;
          it.reg_addr   = on_t2 ? REG_T2CH : REG_T1CH;
          it.write_data = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
          send(it, 0, none);
          n += 2;
        end else begin
          send(rand_item(), 0, none);
          n++;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
